// ----- hw/rtl/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg
// shared types and constants of the 3x3 laplacian sharpening block
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int LSH_MAX_WIDTH     = 2048;  // default line store depth
  localparam int LSH_MAX_HEIGHT    = 4096;
  localparam int LSH_MIN_DIM       = 3;
  localparam int LSH_CENTRE_WEIGHT = 9;
  localparam int LSH_OUT_DEPTH     = 4;     // result queue entries
  localparam int LSH_CH_W          = 8;
  localparam int LSH_NUM_CH        = 3;
  localparam int LSH_WIDTH_W       = 12;
  localparam int LSH_HEIGHT_W      = 13;
  localparam int LSH_ROW_W         = 12;
  localparam int LSH_CFG_W         = 13;
  localparam int LSH_IDX_W         = 1;

  typedef enum logic [LSH_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } lsh_reg_t;

  // one pixel, channel 0 in the low byte
  typedef logic [LSH_NUM_CH-1:0][LSH_CH_W-1:0] lsh_pix_t;

  // one window column, row 0 is the top row
  typedef lsh_pix_t [2:0] lsh_col_t;

  // line store word: pixels of the two previous rows at one column
  typedef struct packed {
    lsh_pix_t middle;
    lsh_pix_t upper;
  } lsh_line_t;

  // per-item control that travels with the pixel
  typedef struct packed {
    logic produce;
    logic done;
  } lsh_tag_t;

  // one result item
  typedef struct packed {
    logic     done;
    lsh_pix_t sharp;
  } lsh_res_t;

endpackage

// ----- hw/rtl/lsh_ram.sv -----
// ----------------------------------------------------------------------------
// lsh_ram
// generic single-clock ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lsh_window.sv -----
// ----------------------------------------------------------------------------
// lsh_window
// 3x3 window registers and the per-channel sharpening kernel
// ----------------------------------------------------------------------------
module lsh_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  lsh_pkg::lsh_col_t in_col,
  input  lsh_pkg::lsh_tag_t in_tag,
  output logic              out_valid,
  output lsh_pkg::lsh_res_t out_res
);

  lsh_pkg::lsh_col_t win_old;
  lsh_pkg::lsh_col_t win_mid;
  lsh_pkg::lsh_col_t kern_left;
  lsh_pkg::lsh_col_t kern_mid;
  lsh_pkg::lsh_col_t kern_right;
  logic              kern_done;

  function automatic logic [lsh_pkg::LSH_CH_W-1:0] sat_byte(logic signed [13:0] v);
    logic [lsh_pkg::LSH_CH_W-1:0] r;
    if (v < 14'sd0) begin
      r = '0;
    end else if (v > 14'sd255) begin
      r = '1;
    end else begin
      r = v[lsh_pkg::LSH_CH_W-1:0];
    end
    return r;
  endfunction

  // window shift; the older column drops out on every pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      win_old   <= '0;
      win_mid   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid & in_tag.produce;
      if (in_valid) begin
        win_old <= win_mid;
        win_mid <= in_col;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      kern_left  <= win_old;
      kern_mid   <= win_mid;
      kern_right <= in_col;
      kern_done  <= in_tag.done;
    end
  end

  // centre weighted nine times, the eight neighbours subtracted
  always_comb begin
    logic [10:0]        nsum;
    logic [11:0]        cw;
    logic signed [13:0] acc;
    out_res.done = kern_done;
    for (int ch = 0; ch < lsh_pkg::LSH_NUM_CH; ch++) begin
      nsum = 11'(kern_left[0][ch]) + 11'(kern_left[1][ch]) + 11'(kern_left[2][ch])
           + 11'(kern_mid[0][ch]) + 11'(kern_mid[2][ch])
           + 11'(kern_right[0][ch]) + 11'(kern_right[1][ch]) + 11'(kern_right[2][ch]);
      cw   = 12'(lsh_pkg::LSH_CENTRE_WEIGHT) * 12'(kern_mid[1][ch]);
      acc  = $signed({2'b00, cw}) - $signed({3'b000, nsum});
      out_res.sharp[ch] = sat_byte(acc);
    end
  end

endmodule

// ----- hw/rtl/lsh_fifo.sv -----
// ----------------------------------------------------------------------------
// lsh_fifo
// small result queue in flops, the head entry drives the output stream
// ----------------------------------------------------------------------------
module lsh_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  lsh_pkg::lsh_res_t          push_data,
  input  logic                       pop,
  output lsh_pkg::lsh_res_t          head,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  lsh_pkg::lsh_res_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic              do_pop;

  assign do_pop = pop && (count != '0);
  assign head   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/laplacian_sharpen_3x3_top.sv -----
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top
// 3x3 laplacian sharpening of a three-channel raster pixel stream
// ----------------------------------------------------------------------------
//  channel   dir   handshake                  payload
//  s_axis    in    tvalid/tready              tdata = pixel_ch0..2
//  m_axis    out   tvalid/tready              tdata = sharp_ch0..2, tlast = frame_done
//  cfg       in    cfg_we (no wait)           cfg_index, cfg_wdata
//
//  one pixel per cycle sustained while the result queue has room; the line
//  store ram has one read and one write port, read at acceptance and written back the next cycle
//  m_axis_tvalid for a result rises after the edge that takes its last pixel,
//  once the stage 1, window kernel and result queue registers have passed it
//  s_axis_tready drops only when the result queue plus in-flight results
//  would fill it, so a stalled output never loses a result
//  reset clears counters, window and queue; line stores need no clearing pass
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top #(
  parameter int MAX_WIDTH = lsh_pkg::LSH_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
  // sharpened output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,   // sharp_ch0, sharp_ch1, sharp_ch2
  output logic                          m_axis_tlast,   // frame_done
  // configuration writes
  input  logic                          cfg_we,
  input  logic [lsh_pkg::LSH_IDX_W-1:0] cfg_index,
  input  logic [lsh_pkg::LSH_CFG_W-1:0] cfg_wdata
);

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column counter
  localparam int WW    = (CW + 1 > lsh_pkg::LSH_WIDTH_W) ? CW + 1 : lsh_pkg::LSH_WIDTH_W;
  localparam int HW    = lsh_pkg::LSH_HEIGHT_W;
  localparam int QD    = lsh_pkg::LSH_OUT_DEPTH;
  localparam int QCW   = $clog2(QD + 1);
  localparam int LINEW = $bits(lsh_pkg::lsh_line_t);

  // configuration registers
  logic [lsh_pkg::LSH_WIDTH_W-1:0] frame_width;
  logic [HW-1:0]                   frame_height;

  // raster position
  logic [CW-1:0]                 column_count;
  logic [lsh_pkg::LSH_ROW_W-1:0] row_count;

  logic [WW-1:0] width_ext;
  logic [WW-1:0] width_eff;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] height_eff;
  logic [HW-1:0] row_inc;
  logic          last_col;
  logic          last_row;
  logic          accept;

  lsh_pkg::lsh_tag_t tag;

  // stage 1: line store data returns
  logic              s1_valid;
  lsh_pkg::lsh_pix_t s1_pix;
  logic [CW-1:0]     s1_addr;
  lsh_pkg::lsh_tag_t s1_tag;
  lsh_pkg::lsh_line_t rd_line;
  lsh_pkg::lsh_line_t wr_line;
  logic [LINEW-1:0]   rd_word;
  lsh_pkg::lsh_col_t  cur_col;

  // stage 2 and result queue
  logic              s2_valid;
  lsh_pkg::lsh_res_t s2_res;
  lsh_pkg::lsh_res_t q_head;
  logic [QCW-1:0]    q_count;
  logic [QCW:0]      q_load;

  // config port; the user is bound to write it only while the block is idle, with no check in the block itself
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= lsh_pkg::LSH_WIDTH_W'(640);
      frame_height <= HW'(480);
    end else if (cfg_we) begin
      unique case (lsh_pkg::lsh_reg_t'(cfg_index))
        lsh_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[lsh_pkg::LSH_WIDTH_W-1:0];
        lsh_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_wdata[HW-1:0];
      endcase
    end
  end

  // effective frame size, clamped to the supported range
  always_comb begin
    width_ext = WW'(frame_width);
    if (width_ext < WW'(lsh_pkg::LSH_MIN_DIM)) begin
      width_eff = WW'(lsh_pkg::LSH_MIN_DIM);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (frame_height < HW'(lsh_pkg::LSH_MIN_DIM)) begin
      height_eff = HW'(lsh_pkg::LSH_MIN_DIM);
    end else if (frame_height > HW'(lsh_pkg::LSH_MAX_HEIGHT)) begin
      height_eff = HW'(lsh_pkg::LSH_MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  // position of the incoming pixel decides whether it closes a window
  assign col_inc     = WW'(column_count) + WW'(1);
  assign row_inc     = HW'(row_count) + HW'(1);
  assign last_col    = (col_inc >= width_eff);
  assign last_row    = (row_inc >= height_eff);
  assign tag.produce = (row_count >= lsh_pkg::LSH_ROW_W'(2)) && (column_count >= CW'(2));
  assign tag.done    = last_row && last_col;

  // room for every result that is already on its way
  assign q_load        = (QCW + 1)'(q_count) + (QCW + 1)'(s1_valid & s1_tag.produce)
                       + (QCW + 1)'(s2_valid);
  assign s_axis_tready = (q_load < (QCW + 1)'(QD));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_inc[lsh_pkg::LSH_ROW_W-1:0];
      end else begin
        column_count <= col_inc[CW-1:0];
      end
    end
  end

  // stage 1 registers; this stage never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix  <= s_axis_tdata;
      s1_addr <= column_count;
      s1_tag  <= tag;
    end
  end

  // line stores: read at the column on acceptance, rows move up on write-back.
  // the same column comes back no sooner than three items later, so the
  // write-back has always landed before it is read again
  lsh_ram #(
    .WIDTH (LINEW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (wr_line),
    .re    (accept),
    .raddr (column_count),
    .rdata (rd_word)
  );

  assign rd_line        = rd_word;
  assign wr_line.upper  = rd_line.middle;
  assign wr_line.middle = s1_pix;

  // newest window column, top row first
  assign cur_col[0] = rd_line.upper;
  assign cur_col[1] = rd_line.middle;
  assign cur_col[2] = s1_pix;

  lsh_window u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_col    (cur_col),
    .in_tag    (s1_tag),
    .out_valid (s2_valid),
    .out_res   (s2_res)
  );

  lsh_fifo #(
    .DEPTH (QD)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (s2_res),
    .pop       (m_axis_tready),
    .head      (q_head),
    .count     (q_count)
  );

  assign m_axis_tvalid = (q_count != '0);
  assign m_axis_tdata  = q_head.sharp;
  assign m_axis_tlast  = q_head.done;

endmodule

// ----- hw/rtl/lsh_checker.sv -----
// ----------------------------------------------------------------------------
// lsh_checker
// port-level checks of the sharpening block, bound to the top level
// ----------------------------------------------------------------------------
module lsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  logic [31:0] in_items;
  logic [31:0] out_items;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_items  <= '0;
      out_items <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_items <= in_items + 32'd1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        out_items <= out_items + 32'd1;
      end
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // input back-pressure only comes from results waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // never more results than items taken
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |-> in_items > out_items)
    else $error("result without a matching input item");

endmodule

bind laplacian_sharpen_3x3_top lsh_checker u_lsh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
